### src/rtch_pkg.sv
// ----------------------------------------------------------------------------
// rtch_pkg: shared types and constants for the ray/triangle closest-hit block
// Payload structs, shared multiply-accumulate micro-program, divider handshake.
// ----------------------------------------------------------------------------
package rtch_pkg;

    localparam int A_W    = 68;   // multiplicand width (widest operand is qv, 67 bits)
    localparam int B_W    = 36;   // multiplier width, split into two 18-bit chunks
    localparam int CH_W   = 19;   // signed chunk width
    localparam int PROD_W = 87;   // A_W + CH_W
    localparam int ACC_W  = 106;  // accumulator width
    localparam int DIV_W  = 122;  // shifted dividend / divisor width
    localparam int Q_W    = 31;   // quotient width

    localparam logic [ACC_W-1:0] DET_EPS  = ACC_W'(28147497);
    localparam logic [17:0]      ONE_Q16  = 18'd65536;
    localparam logic [Q_W-1:0]   DIST_MAX = {Q_W{1'b1}};

    localparam logic [5:0] STEP_TRI_END = 6'd47;  // last micro-step of the triangle ops
    localparam logic [5:0] STEP_PT_BEG  = 6'd48;  // first micro-step of the hit-point ops
    localparam logic [5:0] STEP_PT_END  = 6'd53;

    localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z    = 3'd2;
    localparam logic [2:0] CFG_DIRECTION_X = 3'd3;
    localparam logic [2:0] CFG_DIRECTION_Y = 3'd4;
    localparam logic [2:0] CFG_DIRECTION_Z = 3'd5;

    typedef struct packed {
        logic signed [31:0] vertex_a_x;
        logic signed [31:0] vertex_a_y;
        logic signed [31:0] vertex_a_z;
        logic signed [31:0] vertex_b_x;
        logic signed [31:0] vertex_b_y;
        logic signed [31:0] vertex_b_z;
        logic signed [31:0] vertex_c_x;
        logic signed [31:0] vertex_c_y;
        logic signed [31:0] vertex_c_z;
        logic               last_triangle;
    } in_item_t;

    typedef struct packed {
        logic               hit_found;
        logic [15:0]        hit_index;
        logic [30:0]        hit_distance;
        logic [16:0]        weight_first;
        logic [16:0]        weight_second;
        logic [16:0]        weight_third;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } out_item_t;

    typedef enum logic [4:0] {
        OPN_DX, OPN_DY, OPN_DZ,
        OPN_E1X, OPN_E1Y, OPN_E1Z,
        OPN_E2X, OPN_E2Y, OPN_E2Z,
        OPN_SX, OPN_SY, OPN_SZ,
        OPN_PV0, OPN_PV1, OPN_PV2,
        OPN_QV0, OPN_QV1, OPN_QV2,
        OPN_DIST
    } opnd_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_PV0, DST_PV1, DST_PV2,
        DST_QV0, DST_QV1, DST_QV2,
        DST_DET, DST_UNUM, DST_VNUM, DST_TNUM,
        DST_PX, DST_PY, DST_PZ
    } dst_t;

    typedef struct packed {
        opnd_t a;
        opnd_t b;
        logic  neg;
        logic  last;
        dst_t  dst;
    } mac_op_t;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] num;
        logic [ACC_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } div_rsp_t;

    // product list: pv = d x e2, qv = s x e1, det/unum/vnum/tnum dots, then d * distance
    function automatic mac_op_t op_info(input logic [4:0] op);
        mac_op_t r;
        r = '{OPN_DX, OPN_DX, 1'b0, 1'b0, DST_NONE};
        unique case (op)
            5'd0:  r = '{OPN_E2Z, OPN_DY,  1'b0, 1'b0, DST_NONE};
            5'd1:  r = '{OPN_E2Y, OPN_DZ,  1'b1, 1'b1, DST_PV0};
            5'd2:  r = '{OPN_E2X, OPN_DZ,  1'b0, 1'b0, DST_NONE};
            5'd3:  r = '{OPN_E2Z, OPN_DX,  1'b1, 1'b1, DST_PV1};
            5'd4:  r = '{OPN_E2Y, OPN_DX,  1'b0, 1'b0, DST_NONE};
            5'd5:  r = '{OPN_E2X, OPN_DY,  1'b1, 1'b1, DST_PV2};
            5'd6:  r = '{OPN_SY,  OPN_E1Z, 1'b0, 1'b0, DST_NONE};
            5'd7:  r = '{OPN_SZ,  OPN_E1Y, 1'b1, 1'b1, DST_QV0};
            5'd8:  r = '{OPN_SZ,  OPN_E1X, 1'b0, 1'b0, DST_NONE};
            5'd9:  r = '{OPN_SX,  OPN_E1Z, 1'b1, 1'b1, DST_QV1};
            5'd10: r = '{OPN_SX,  OPN_E1Y, 1'b0, 1'b0, DST_NONE};
            5'd11: r = '{OPN_SY,  OPN_E1X, 1'b1, 1'b1, DST_QV2};
            5'd12: r = '{OPN_PV0, OPN_E1X, 1'b0, 1'b0, DST_NONE};
            5'd13: r = '{OPN_PV1, OPN_E1Y, 1'b0, 1'b0, DST_NONE};
            5'd14: r = '{OPN_PV2, OPN_E1Z, 1'b0, 1'b1, DST_DET};
            5'd15: r = '{OPN_PV0, OPN_SX,  1'b0, 1'b0, DST_NONE};
            5'd16: r = '{OPN_PV1, OPN_SY,  1'b0, 1'b0, DST_NONE};
            5'd17: r = '{OPN_PV2, OPN_SZ,  1'b0, 1'b1, DST_UNUM};
            5'd18: r = '{OPN_QV0, OPN_DX,  1'b0, 1'b0, DST_NONE};
            5'd19: r = '{OPN_QV1, OPN_DY,  1'b0, 1'b0, DST_NONE};
            5'd20: r = '{OPN_QV2, OPN_DZ,  1'b0, 1'b1, DST_VNUM};
            5'd21: r = '{OPN_QV0, OPN_E2X, 1'b0, 1'b0, DST_NONE};
            5'd22: r = '{OPN_QV1, OPN_E2Y, 1'b0, 1'b0, DST_NONE};
            5'd23: r = '{OPN_QV2, OPN_E2Z, 1'b0, 1'b1, DST_TNUM};
            5'd24: r = '{OPN_DX,  OPN_DIST, 1'b0, 1'b1, DST_PX};
            5'd25: r = '{OPN_DY,  OPN_DIST, 1'b0, 1'b1, DST_PY};
            5'd26: r = '{OPN_DZ,  OPN_DIST, 1'b0, 1'b1, DST_PZ};
            default: r = '{OPN_DX, OPN_DX, 1'b0, 1'b0, DST_NONE};
        endcase
        return r;
    endfunction

endpackage

### src/rtch_div.sv
// ----------------------------------------------------------------------------
// rtch_div: restoring divider, floor(num * 65536 / den) saturated to 31 bits
// One quotient bit per cycle; num >= 0 and den > 0 are expected.
// ----------------------------------------------------------------------------
module rtch_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rtch_pkg::div_req_t req,
    output rtch_pkg::div_rsp_t rsp
);
    import rtch_pkg::*;

    typedef enum logic {D_IDLE, D_RUN} dstate_t;

    dstate_t          state_reg;
    logic             done_reg;
    logic [Q_W-1:0]   quot_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [4:0]       cnt_reg;

    logic [DIV_W-1:0] n0;
    logic [DIV_W-1:0] dsat;
    logic             ge;

    assign n0   = DIV_W'(req.num) << 16;
    assign dsat = DIV_W'(req.den) << 31;
    assign ge   = rem_reg >= dvs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        if (n0 >= dsat)
                        begin
                            quot_reg <= DIST_MAX;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            rem_reg   <= n0;
                            dvs_reg   <= DIV_W'(req.den) << 30;
                            quot_reg  <= '0;
                            cnt_reg   <= 5'd30;
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    if (ge)
                    begin
                        rem_reg <= rem_reg - dvs_reg;
                    end
                    quot_reg <= {quot_reg[Q_W-2:0], ge};
                    dvs_reg  <= dvs_reg >> 1;
                    if (cnt_reg == 5'd0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

### src/ray_triangle_closest_hit_top.sv
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_top: nearest ray/triangle hit over a triangle stream
// Moller-Trumbore test in exact fixed point on one shared multiply-accumulate
// unit and one shared divider, keeping the nearest hit of each mesh.
// ----------------------------------------------------------------------------
//  channel | signals                          | transfer
//  in      | in_valid, in_ready, in_data      | in_valid & in_ready
//  out     | out_valid, out_ready, out_data   | out_valid & out_ready
//  cfg     | cfg_we, cfg_index, cfg_wdata     | cfg_we
//
//  each triangle: accept, products through the one 68x19 multiplier, then drain,
//  sign fold, range check and count; a hit adds one divide for the distance, and
//  a new best two more divides for the weights.
//  a last triangle adds an emit step, and the hit-point products before it when a hit was kept.
//  in_ready is high only between triangles; a waiting result stalls the block only
//  when the next result is ready to leave.
//  reset is asynchronous, clears the search state and the ray origin, and sets the ray direction to +z.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rtch_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rtch_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wdata
);
    import rtch_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_DRAIN, S_FOLD, S_CHECK, S_DIV_T, S_DIV_U, S_DIV_V,
        S_NEXT, S_PT_MAC, S_PT_DRAIN, S_EMIT
    } state_t;

    state_t state_reg;

    logic signed [31:0] origin_reg [3];
    logic signed [17:0] dir_reg    [3];

    logic signed [32:0] e1_reg [3];
    logic signed [32:0] e2_reg [3];
    logic signed [32:0] s_reg  [3];
    logic signed [51:0] pv_reg [3];
    logic signed [66:0] qv_reg [3];
    logic signed [ACC_W-1:0] det_reg, unum_reg, vnum_reg, tnum_reg;
    logic signed [31:0] point_reg [3];
    logic               last_reg;
    logic [5:0]         step_reg;

    logic [15:0]    counter_reg;
    logic           best_found_reg;
    logic [15:0]    best_index_reg;
    logic [Q_W-1:0] best_dist_reg;
    logic [16:0]    best_ws_reg;
    logic [16:0]    best_wt_reg;

    logic             div_start_reg;
    logic [ACC_W-1:0] div_num_reg;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    // multiply-accumulate path
    logic                     mac_issue;
    mac_op_t                  cur_op;
    logic signed [A_W-1:0]    a_val;
    logic signed [B_W-1:0]    b_val;
    logic signed [CH_W-1:0]   chunk;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     tag_valid_reg, tag_lo_reg, tag_neg_reg, tag_last_reg;
    dst_t                     tag_dst_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext, addend, acc_sum;

    logic                    hit_ok;
    logic signed [ACC_W:0]   uv_sum;
    logic                    better;

    function automatic logic signed [31:0] sat_point(input logic signed [31:0] o,
                                                     input logic signed [ACC_W-1:0] p);
        logic signed [33:0] s;
        s = 34'(o) + 34'(p >>> 16);
        if (s > 34'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (s < -34'sd2147483648)
            return 32'sh80000000;
        else
            return s[31:0];
    endfunction

    assign mac_issue = (state_reg == S_MAC) || (state_reg == S_PT_MAC);
    assign cur_op    = op_info(step_reg[5:1]);

    always_comb
    begin
        unique case (cur_op.a)
            OPN_DX:  a_val = A_W'(dir_reg[0]);
            OPN_DY:  a_val = A_W'(dir_reg[1]);
            OPN_DZ:  a_val = A_W'(dir_reg[2]);
            OPN_E2X: a_val = A_W'(e2_reg[0]);
            OPN_E2Y: a_val = A_W'(e2_reg[1]);
            OPN_E2Z: a_val = A_W'(e2_reg[2]);
            OPN_SX:  a_val = A_W'(s_reg[0]);
            OPN_SY:  a_val = A_W'(s_reg[1]);
            OPN_SZ:  a_val = A_W'(s_reg[2]);
            OPN_PV0: a_val = A_W'(pv_reg[0]);
            OPN_PV1: a_val = A_W'(pv_reg[1]);
            OPN_PV2: a_val = A_W'(pv_reg[2]);
            OPN_QV0: a_val = A_W'(qv_reg[0]);
            OPN_QV1: a_val = A_W'(qv_reg[1]);
            OPN_QV2: a_val = A_W'(qv_reg[2]);
            default: a_val = '0;
        endcase
    end

    always_comb
    begin
        unique case (cur_op.b)
            OPN_DX:   b_val = B_W'(dir_reg[0]);
            OPN_DY:   b_val = B_W'(dir_reg[1]);
            OPN_DZ:   b_val = B_W'(dir_reg[2]);
            OPN_E1X:  b_val = B_W'(e1_reg[0]);
            OPN_E1Y:  b_val = B_W'(e1_reg[1]);
            OPN_E1Z:  b_val = B_W'(e1_reg[2]);
            OPN_E2X:  b_val = B_W'(e2_reg[0]);
            OPN_E2Y:  b_val = B_W'(e2_reg[1]);
            OPN_E2Z:  b_val = B_W'(e2_reg[2]);
            OPN_SX:   b_val = B_W'(s_reg[0]);
            OPN_SY:   b_val = B_W'(s_reg[1]);
            OPN_SZ:   b_val = B_W'(s_reg[2]);
            OPN_DIST: b_val = B_W'({1'b0, best_dist_reg});
            default:  b_val = '0;
        endcase
    end

    // high chunk signed and weighted by 2^18, low chunk unsigned
    assign chunk    = step_reg[0] ? {1'b0, b_val[17:0]} : {b_val[35], b_val[35:18]};
    assign prod_ext = ACC_W'(prod_reg);
    assign addend   = tag_lo_reg ? prod_ext : (prod_ext <<< 18);
    assign acc_sum  = acc_reg + (tag_neg_reg ? -addend : addend);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            tag_valid_reg <= mac_issue;
            if (mac_issue)
            begin
                prod_reg     <= a_val * chunk;
                tag_lo_reg   <= step_reg[0];
                tag_neg_reg  <= cur_op.neg;
                tag_last_reg <= cur_op.last;
                tag_dst_reg  <= cur_op.dst;
            end
            if (tag_valid_reg)
            begin
                if (tag_last_reg && tag_lo_reg)
                begin
                    acc_reg <= '0;
                    unique case (tag_dst_reg)
                        DST_PV0:  pv_reg[0] <= acc_sum[51:0];
                        DST_PV1:  pv_reg[1] <= acc_sum[51:0];
                        DST_PV2:  pv_reg[2] <= acc_sum[51:0];
                        DST_QV0:  qv_reg[0] <= acc_sum[66:0];
                        DST_QV1:  qv_reg[1] <= acc_sum[66:0];
                        DST_QV2:  qv_reg[2] <= acc_sum[66:0];
                        DST_DET:  det_reg   <= acc_sum;
                        DST_UNUM: unum_reg  <= acc_sum;
                        DST_VNUM: vnum_reg  <= acc_sum;
                        DST_TNUM: tnum_reg  <= acc_sum;
                        DST_PX:   point_reg[0] <= sat_point(origin_reg[0], acc_sum);
                        DST_PY:   point_reg[1] <= sat_point(origin_reg[1], acc_sum);
                        DST_PZ:   point_reg[2] <= sat_point(origin_reg[2], acc_sum);
                        default:  ;
                    endcase
                end
                else
                begin
                    acc_reg <= acc_sum;
                end
            end
            // sign fold of the determinant and numerators
            if (state_reg == S_FOLD && det_reg[ACC_W-1])
            begin
                det_reg  <= -det_reg;
                unum_reg <= -unum_reg;
                vnum_reg <= -vnum_reg;
                tnum_reg <= -tnum_reg;
            end
        end
    end

    assign uv_sum = (ACC_W+1)'(unum_reg) + (ACC_W+1)'(vnum_reg);
    assign hit_ok = (det_reg > $signed(DET_EPS))
                 && !unum_reg[ACC_W-1] && (unum_reg <= det_reg)
                 && !vnum_reg[ACC_W-1] && (uv_sum <= (ACC_W+1)'(det_reg))
                 && !tnum_reg[ACC_W-1];
    assign better = (div_rsp.quot != '0)
                 && (!best_found_reg || (div_rsp.quot < best_dist_reg));

    assign div_req.start = div_start_reg;
    assign div_req.num   = div_num_reg;
    assign div_req.den   = det_reg;

    rtch_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            origin_reg[0]  <= '0;
            origin_reg[1]  <= '0;
            origin_reg[2]  <= '0;
            dir_reg[0]     <= '0;
            dir_reg[1]     <= '0;
            dir_reg[2]     <= 18'sd65536;
            step_reg       <= '0;
            counter_reg    <= '0;
            best_found_reg <= 1'b0;
            best_index_reg <= '0;
            best_dist_reg  <= '0;
            best_ws_reg    <= '0;
            best_wt_reg    <= '0;
            div_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ORIGIN_X:    origin_reg[0] <= cfg_wdata;
                    CFG_ORIGIN_Y:    origin_reg[1] <= cfg_wdata;
                    CFG_ORIGIN_Z:    origin_reg[2] <= cfg_wdata;
                    CFG_DIRECTION_X: dir_reg[0]    <= cfg_wdata[17:0];
                    CFG_DIRECTION_Y: dir_reg[1]    <= cfg_wdata[17:0];
                    CFG_DIRECTION_Z: dir_reg[2]    <= cfg_wdata[17:0];
                    default:         dir_reg[2]    <= dir_reg[2];
                endcase
            end

            // divide starts: distance after the range check, weights after a new best
            div_start_reg <= ((state_reg == S_CHECK) && hit_ok)
                          || ((state_reg == S_DIV_T) && div_rsp.done && better)
                          || ((state_reg == S_DIV_U) && div_rsp.done);

            if (out_valid_reg && out_ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        e1_reg[0] <= 33'(in_data.vertex_b_x) - 33'(in_data.vertex_a_x);
                        e1_reg[1] <= 33'(in_data.vertex_b_y) - 33'(in_data.vertex_a_y);
                        e1_reg[2] <= 33'(in_data.vertex_b_z) - 33'(in_data.vertex_a_z);
                        e2_reg[0] <= 33'(in_data.vertex_c_x) - 33'(in_data.vertex_a_x);
                        e2_reg[1] <= 33'(in_data.vertex_c_y) - 33'(in_data.vertex_a_y);
                        e2_reg[2] <= 33'(in_data.vertex_c_z) - 33'(in_data.vertex_a_z);
                        s_reg[0]  <= 33'(origin_reg[0]) - 33'(in_data.vertex_a_x);
                        s_reg[1]  <= 33'(origin_reg[1]) - 33'(in_data.vertex_a_y);
                        s_reg[2]  <= 33'(origin_reg[2]) - 33'(in_data.vertex_a_z);
                        last_reg  <= in_data.last_triangle;
                        step_reg  <= '0;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == STEP_TRI_END)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: state_reg <= S_FOLD;
                S_FOLD:  state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if (hit_ok)
                    begin
                        div_num_reg   <= tnum_reg;
                        state_reg     <= S_DIV_T;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_DIV_T:
                begin
                    if (div_rsp.done)
                    begin
                        if (better)
                        begin
                            best_found_reg <= 1'b1;
                            best_index_reg <= counter_reg;
                            best_dist_reg  <= div_rsp.quot;
                            div_num_reg    <= unum_reg;
                            state_reg      <= S_DIV_U;
                        end
                        else
                        begin
                            state_reg <= S_NEXT;
                        end
                    end
                end
                S_DIV_U:
                begin
                    if (div_rsp.done)
                    begin
                        best_ws_reg   <= div_rsp.quot[16:0];
                        div_num_reg   <= vnum_reg;
                        state_reg     <= S_DIV_V;
                    end
                end
                S_DIV_V:
                begin
                    if (div_rsp.done)
                    begin
                        best_wt_reg <= div_rsp.quot[16:0];
                        state_reg   <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    counter_reg <= counter_reg + 16'd1;
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (best_found_reg)
                    begin
                        step_reg  <= STEP_PT_BEG;
                        state_reg <= S_PT_MAC;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_PT_MAC:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == STEP_PT_END)
                    begin
                        state_reg <= S_PT_DRAIN;
                    end
                end
                S_PT_DRAIN: state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        if (best_found_reg)
                        begin
                            out_data_reg.hit_found     <= 1'b1;
                            out_data_reg.hit_index     <= best_index_reg;
                            out_data_reg.hit_distance  <= best_dist_reg;
                            out_data_reg.weight_first  <=
                                17'(ONE_Q16 - 18'(best_ws_reg) - 18'(best_wt_reg));
                            out_data_reg.weight_second <= best_ws_reg;
                            out_data_reg.weight_third  <= best_wt_reg;
                            out_data_reg.point_x       <= point_reg[0];
                            out_data_reg.point_y       <= point_reg[1];
                            out_data_reg.point_z       <= point_reg[2];
                        end
                        else
                        begin
                            out_data_reg <= '0;
                        end
                        counter_reg    <= '0;
                        best_found_reg <= 1'b0;
                        best_index_reg <= '0;
                        best_dist_reg  <= '0;
                        best_ws_reg    <= '0;
                        best_wt_reg    <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a triangle is in work");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside the emit step");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit_found |->
            out_data.hit_index == '0 && out_data.hit_distance == '0)
        else $error("miss result carries a nonzero field");

    a_weights_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit_found |->
            (18'(out_data.weight_second) + 18'(out_data.weight_third)) <= ONE_Q16)
        else $error("barycentric weights exceed one");

    a_div_only_when_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV_T || state_reg == S_DIV_U
                      || state_reg == S_DIV_V)
        else $error("divider finished outside a divide step");

endmodule

### test/ray_triangle_closest_hit_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_top_tb: closest-hit search over random meshes
// Streams meshes of triangles through the block under several ray settings.
// An exact fixed-point predictor computes each mesh's nearest hit, and the
// monitor checks every result transfer field by field.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_top_tb;
    import rtch_pkg::*;

    typedef logic signed [159:0] acc_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;

    in_item_t  triangles_pending[$];
    out_item_t hit_reports_due[$];
    int        errors;
    bit        gaps_on;
    int        send_gap;
    int        recv_hold;

    // ray registers and search state as the block should hold them
    logic signed [31:0] ray_org[3];
    logic signed [17:0] ray_dir[3];
    logic [15:0]        tri_count;
    logic               best_hit;
    logic [15:0]        best_idx;
    logic [30:0]        best_dist;
    logic [16:0]        best_w2;
    logic [16:0]        best_w3;

    ray_triangle_closest_hit_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [30:0] q16_quotient(input acc_t num, input acc_t den);
        acc_t n;
        n = num <<< 16;
        if (n >= (den <<< 31))
            return DIST_MAX;
        return 31'(n / den);
    endfunction

    function automatic void cross_prod(input acc_t a[3], input acc_t b[3],
                                       output acc_t r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic acc_t dot_prod(input acc_t a[3], input acc_t b[3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic void trace_triangle(input in_item_t t);
        longint     va[3], vb[3], vc[3];
        acc_t       e1[3], e2[3], s[3], dv[3], pv[3], qv[3];
        acc_t       det, unum, vnum, tnum;
        logic       hit;
        logic [30:0] tq;
        longint     pt;
        out_item_t  r;
        va = '{t.vertex_a_x, t.vertex_a_y, t.vertex_a_z};
        vb = '{t.vertex_b_x, t.vertex_b_y, t.vertex_b_z};
        vc = '{t.vertex_c_x, t.vertex_c_y, t.vertex_c_z};
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = acc_t'(vb[i] - va[i]);
            e2[i] = acc_t'(vc[i] - va[i]);
            s[i]  = acc_t'(longint'(ray_org[i]) - va[i]);
            dv[i] = acc_t'(ray_dir[i]);
        end
        cross_prod(dv, e2, pv);
        det  = dot_prod(e1, pv);
        unum = dot_prod(s, pv);
        cross_prod(s, e1, qv);
        vnum = dot_prod(dv, qv);
        tnum = dot_prod(e2, qv);
        if (det < 0)
        begin
            det  = -det;
            unum = -unum;
            vnum = -vnum;
            tnum = -tnum;
        end
        hit = !(det <= acc_t'(28147497) || unum < 0 || unum > det || vnum < 0
                || unum + vnum > det || tnum < 0);
        if (hit)
        begin
            tq = q16_quotient(tnum, det);
            if (tq != 0 && (!best_hit || tq < best_dist))
            begin
                best_hit  = 1'b1;
                best_idx  = tri_count;
                best_dist = tq;
                best_w2   = 17'(q16_quotient(unum, det));
                best_w3   = 17'(q16_quotient(vnum, det));
            end
        end
        tri_count = tri_count + 16'd1;
        if (!t.last_triangle)
            return;
        r = '0;
        if (best_hit)
        begin
            r.hit_found     = 1'b1;
            r.hit_index     = best_idx;
            r.hit_distance  = best_dist;
            r.weight_first  = 17'(32'd65536 - best_w2 - best_w3);
            r.weight_second = best_w2;
            r.weight_third  = best_w3;
            for (int i = 0; i < 3; i++)
            begin
                pt = longint'(ray_org[i])
                     + ((longint'(ray_dir[i]) * longint'({1'b0, best_dist})) >>> 16);
                if (pt > 64'sd2147483647)
                    pt = 64'sd2147483647;
                if (pt < -64'sd2147483648)
                    pt = -64'sd2147483648;
                case (i)
                    0: r.point_x = 32'(pt);
                    1: r.point_y = 32'(pt);
                    default: r.point_z = 32'(pt);
                endcase
            end
        end
        hit_reports_due.push_back(r);
        tri_count = '0;
        best_hit  = 1'b0;
        best_idx  = '0;
        best_dist = '0;
        best_w2   = '0;
        best_w3   = '0;
    endfunction

    // triangle driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                trace_triangle(in_data);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (triangles_pending.size() > 0)
                begin
                    in_data  <= triangles_pending.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= gaps_on ? $urandom_range(0, 3) : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp,
                               input logic [31:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
            errors++;
        end
    endtask

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        int draw;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_hold <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (hit_reports_due.size() == 0)
            begin
                $display("%0t: unexpected result transfer %h", $time, out_data);
                errors++;
            end
            else
            begin
                e = hit_reports_due.pop_front();
                check_field("hit_found", e.hit_found, out_data.hit_found);
                check_field("hit_index", e.hit_index, out_data.hit_index);
                check_field("hit_distance", e.hit_distance, out_data.hit_distance);
                check_field("weight_first", e.weight_first, out_data.weight_first);
                check_field("weight_second", e.weight_second, out_data.weight_second);
                check_field("weight_third", e.weight_third, out_data.weight_third);
                check_field("point_x", e.point_x, out_data.point_x);
                check_field("point_y", e.point_y, out_data.point_y);
                check_field("point_z", e.point_z, out_data.point_z);
            end
            draw = gaps_on ? $urandom_range(0, 3) : 0;
            recv_hold <= draw;
            out_ready <= (draw == 0);
        end
        else if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            out_ready <= (recv_hold == 1);
        end
        else
            out_ready <= 1'b1;
    end

    task automatic write_reg(input logic [2:0] idx, input logic signed [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ORIGIN_X:    ray_org[0] = val;
            CFG_ORIGIN_Y:    ray_org[1] = val;
            CFG_ORIGIN_Z:    ray_org[2] = val;
            CFG_DIRECTION_X: ray_dir[0] = val[17:0];
            CFG_DIRECTION_Y: ray_dir[1] = val[17:0];
            default:         ray_dir[2] = val[17:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_ray(input int ox, input int oy, input int oz,
                           input int dx, input int dy, input int dz);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_DIRECTION_X, dx);
        write_reg(CFG_DIRECTION_Y, dy);
        write_reg(CFG_DIRECTION_Z, dz);
    endtask

    // every triangle accepted, every result seen, then room for a trailing search
    task automatic wait_quiet();
        while (triangles_pending.size() > 0 || in_valid || hit_reports_due.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic in_item_t make_tri(input int ax, input int ay, input int az,
                                          input int bx, input int by, input int bz,
                                          input int cx, input int cy, input int cz,
                                          input bit last);
        in_item_t t;
        t = '{ax, ay, az, bx, by, bz, cx, cy, cz, last};
        return t;
    endfunction

    // meshes built mostly around a point on the ray so that many triangles hit
    task automatic queue_meshes(input int count);
        in_item_t t, prev;
        int n, sent, kind, r;
        longint span, cpt[3];
        sent = 0;
        prev = '0;
        while (sent < count)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
            begin
                kind = $urandom_range(0, 11);
                if (kind == 0)
                    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, 1'b0};
                else if (kind == 1)
                    t = prev;
                else
                begin
                    span = (kind == 2) ? longint'($urandom) : $urandom_range(1, 1 << 22);
                    for (int i = 0; i < 3; i++)
                        cpt[i] = longint'(ray_org[i]) + ((longint'(ray_dir[i]) * span) >>> 16);
                    r = 1 << $urandom_range(3, 22);
                    t.vertex_a_x = 32'(cpt[0] + $urandom_range(0, 2 * r) - r);
                    t.vertex_a_y = 32'(cpt[1] + $urandom_range(0, 2 * r) - r);
                    t.vertex_a_z = 32'(cpt[2] + $urandom_range(0, 2 * r) - r);
                    t.vertex_b_x = 32'(cpt[0] + $urandom_range(0, 2 * r) - r);
                    t.vertex_b_y = 32'(cpt[1] + $urandom_range(0, 2 * r) - r);
                    t.vertex_b_z = 32'(cpt[2] + $urandom_range(0, 2 * r) - r);
                    t.vertex_c_x = 32'(cpt[0] + $urandom_range(0, 2 * r) - r);
                    t.vertex_c_y = 32'(cpt[1] + $urandom_range(0, 2 * r) - r);
                    t.vertex_c_z = 32'(cpt[2] + $urandom_range(0, 2 * r) - r);
                end
                t.last_triangle = (k == n - 1);
                prev = t;
                triangles_pending.push_back(t);
                sent++;
            end
        end
    endtask

    initial
    begin
        errors    = 0;
        gaps_on   = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ORIGIN_X;
        cfg_wdata = '0;
        ray_org   = '{0, 0, 0};
        ray_dir   = '{0, 0, 18'sd65536};
        tri_count = '0;
        best_hit  = 1'b0;
        best_idx  = '0;
        best_dist = '0;
        best_w2   = '0;
        best_w3   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset ray: origin zero, looking along +z
        triangles_pending.push_back(make_tri(-65536, -65536, 327680, 131072, -65536, 327680,
                                             -65536, 131072, 327680, 1'b0));
        triangles_pending.push_back(make_tri(-65536, -65536, 131072, 131072, -65536, 131072,
                                             -65536, 131072, 131072, 1'b0));
        // same distance again: the earlier one stays
        triangles_pending.push_back(make_tri(-65536, -65536, 131072, 131072, -65536, 131072,
                                             -65536, 131072, 131072, 1'b0));
        // behind the origin
        triangles_pending.push_back(make_tri(-65536, -65536, -196608, 131072, -65536,
                                             -196608, -65536, 131072, -196608, 1'b1));
        // degenerate triangle
        triangles_pending.push_back(make_tri(65536, 65536, 65536, 65536, 65536, 65536,
                                             65536, 65536, 65536, 1'b1));
        triangles_pending.push_back(make_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                             1'b1));
        triangles_pending.push_back(make_tri(32'h80000000, 32'h80000000, 32'h80000000,
                                             32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                             32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                             1'b1));
        // ray passes exactly through a corner
        triangles_pending.push_back(make_tri(0, 0, 196608, 65536, 0, 196608,
                                             0, 65536, 196608, 1'b1));
        // ray passes through the middle of an edge
        triangles_pending.push_back(make_tri(-65536, 0, 196608, 65536, 0, 196608,
                                             0, -65536, 196608, 1'b1));
        // hit at distance zero does not count
        triangles_pending.push_back(make_tri(-65536, -65536, 0, 131072, -65536, 0,
                                             -65536, 131072, 0, 1'b1));
        // parallel to the ray
        triangles_pending.push_back(make_tri(0, 0, 65536, 65536, 0, 65536,
                                             0, 0, 131072, 1'b1));
        wait_quiet();

        // far hit that saturates the distance
        set_ray(0, 0, 32'h80000000, 0, 0, 65536);
        triangles_pending.push_back(make_tri(-65536, -65536, 32'h7fff0000, 131072, -65536,
                                             32'h7fff0000, -65536, 131072, 32'h7fff0000,
                                             1'b1));
        wait_quiet();

        for (int ph = 0; ph < 10; ph++)
        begin
            gaps_on = (ph % 3 != 1);
            case (ph)
                0: set_ray(0, 0, 0, 0, 0, 65536);
                1: set_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, -65536, 0, 0);
                2: set_ray(32'h80000000, 32'h80000000, 32'h80000000, 65536, 0, 0);
                3: set_ray(12345678, -7654321, 1000, 0, -65536, 0);
                4: set_ray(-300000, 200000, 5000000, 0, 0, -65536);
                5: set_ray(0, 65536, -65536, 37837, 37837, 37837);
                6: set_ray(32'h7fff0000, 0, 32'h80010000, -46341, 0, 46341);
                default: set_ray($urandom, $urandom_range(0, 1 << 24), $urandom,
                                 $urandom_range(0, 131072) - 65536,
                                 $urandom_range(0, 131072) - 65536,
                                 $urandom_range(0, 131072) - 65536);
            endcase
            queue_meshes(180);
            wait_quiet();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("simulation failed");
        $finish;
    end

endmodule
